[sv/ffha_pkg.sv]
// Shared constants and types for the first-fit heap allocator.
package ffha_pkg;

    localparam int HEAP_WORDS = 8192;
    localparam int IDX_W      = $clog2(HEAP_WORDS);
    localparam int OFF_W      = IDX_W + 3;
    localparam int CMP_W      = (OFF_W + 2 > 19) ? OFF_W + 2 : 19;
    localparam int LIMIT_W    = 17;
    localparam int SIZE_W     = 17;

    typedef logic [63:0]      word_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam word_t HEAP_MAGIC = 64'h2A8F_30B2_41BF_A759;

    localparam logic [CMP_W-1:0] HDR_BYTES   = CMP_W'(24);
    localparam logic [CMP_W-1:0] STORE_BYTES = CMP_W'(HEAP_WORDS * 8);
    localparam logic [CMP_W-1:0] ADDR_SPAN   =
        CMP_W'((HEAP_WORDS * 8 < 65536) ? HEAP_WORDS * 8 : 65536);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_OOM     = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

endpackage

[sv/first_fit_heap_allocator.sv]
// First-fit heap allocator over an implicit list of block headers in one heap memory.
//
// After reset the block sweeps the heap memory to zero, one word per cycle, with
// busy high. A request is taken when start is high and busy is low; its result
// appears on address and status for one cycle with done high and must be taken
// then. A zero-size allocate, a null free or a free rejected by its address is
// answered from the idle state without a memory access. A free reads the size
// and magic words of its header, checks them and, if valid, clears the allocated
// bit. An allocate walks the headers through the single read port, reading the
// size and magic words of each; it reuses the first free block that fits, or
// appends a new header and terminator after the last block through the single
// write port. A new request can be taken in the cycle its predecessor's result is shown.
module first_fit_heap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [15:0]                   request_size,
    input  logic [15:0]                   free_address,
    input  logic                          cfg_we,
    input  logic [ffha_pkg::LIMIT_W-1:0]  cfg_data,
    output logic                          done,
    output logic [15:0]                   address,
    output logic [1:0]                    status
);
    import ffha_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RSZ   = 3'd2;
    localparam logic [2:0] S_RMG   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_APP   = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;

    word_t mem [HEAP_WORDS];
    word_t rd_data_reg;

    logic [2:0]         state_reg,  state_next;
    logic [OFF_W-1:0]   b_reg,      b_next;
    logic [OFF_W-1:0]   prev_reg,   prev_next;
    logic [OFF_W-1:0]   t_reg,      t_next;
    logic [SIZE_W-1:0]  n_reg,      n_next;
    logic               kind_reg,   kind_next;
    word_t              sz_reg,     sz_next;
    logic [2:0]         cnt_reg,    cnt_next;
    idx_t               clr_reg,    clr_next;
    logic [LIMIT_W-1:0] lim_reg;
    logic               done_reg,   done_next;
    logic [15:0]        addr_reg,   addr_next;
    logic [1:0]         status_reg, status_next;

    logic               accept;
    logic [SIZE_W-1:0]  req_sum;
    logic [SIZE_W-1:0]  n_req;
    logic [CMP_W-1:0]   b_ext;
    logic [CMP_W-1:0]   n_ext;
    logic [CMP_W-1:0]   fa_ext;
    logic [CMP_W-1:0]   off_sz;
    logic [CMP_W-1:0]   prev_low;
    logic [CMP_W-1:0]   b_step;
    logic [CMP_W-1:0]   need;
    logic [CMP_W-1:0]   t_sum;
    logic [CMP_W-1:0]   addr_sum;
    logic [CMP_W-1:0]   fa_base;
    logic [CMP_W-1:0]   lim_ext;
    logic [CMP_W-1:0]   lim_eff;
    logic               sz_big;
    logic               fits;
    logic               magic_ok;
    idx_t               idx_mg;
    idx_t               idx_sz;
    idx_t               idx_base;
    idx_t               rd_idx;
    idx_t               wr_idx;
    logic               wr_en;
    word_t              wr_data;

    always_comb
    begin
        accept   = start && !busy;
        req_sum  = {1'b0, request_size} + SIZE_W'(7);
        n_req    = {req_sum[SIZE_W-1:3], 3'b000};
        b_ext    = CMP_W'(b_reg);
        n_ext    = CMP_W'(n_reg);
        fa_ext   = CMP_W'(free_address);
        fa_base  = fa_ext - HDR_BYTES;
        off_sz   = b_ext + CMP_W'(16);
        idx_mg   = b_reg[OFF_W-1:3];
        idx_sz   = off_sz[OFF_W-1:3];
        sz_big   = |sz_reg[63:OFF_W];
        prev_low = CMP_W'({sz_reg[OFF_W-1:1], 1'b0});
        b_step   = b_ext + HDR_BYTES + prev_low;
        fits     = !sz_reg[0] && ({sz_reg[63:1], 1'b0} >= 64'(n_reg));
        magic_ok = (rd_data_reg == HEAP_MAGIC);
        need     = b_ext + HDR_BYTES + HDR_BYTES + n_ext;
        t_sum    = b_ext + HDR_BYTES + n_ext;
        addr_sum = b_ext + HDR_BYTES;
        lim_ext  = CMP_W'(lim_reg);
        lim_eff  = (lim_ext > ADDR_SPAN) ? ADDR_SPAN : lim_ext;
        idx_base = (cnt_reg < 3'd3) ? b_reg[OFF_W-1:3] : t_reg[OFF_W-1:3];
    end

    always_comb
    begin
        state_next  = state_reg;
        b_next      = b_reg;
        prev_next   = prev_reg;
        t_next      = t_reg;
        n_next      = n_reg;
        kind_next   = kind_reg;
        sz_next     = sz_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        addr_next   = addr_reg;
        status_next = status_reg;
        rd_idx      = idx_sz;
        wr_en       = 1'b0;
        wr_idx      = clr_reg;
        wr_data     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + idx_t'(1);
                if (clr_reg == idx_t'(HEAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kind;
                    addr_next = '0;
                    if (kind == KIND_ALLOC)
                    begin
                        if (request_size == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_ZERO;
                        end
                        else
                        begin
                            n_next     = n_req;
                            b_next     = '0;
                            prev_next  = '0;
                            state_next = S_RSZ;
                        end
                    end
                    else
                    begin
                        priority if (free_address == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                        else if (fa_ext < HDR_BYTES || free_address[2:0] != 3'b000
                                 || fa_ext > STORE_BYTES)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_BADFREE;
                        end
                        else
                        begin
                            b_next     = fa_base[OFF_W-1:0];
                            state_next = S_RSZ;
                        end
                    end
                end
            end
            S_RSZ:
            begin
                rd_idx     = idx_sz;
                state_next = S_RMG;
            end
            S_RMG:
            begin
                rd_idx  = idx_mg;
                sz_next = rd_data_reg;
                if (kind_reg == KIND_ALLOC && rd_data_reg == '0)
                begin
                    state_next = S_APP;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (kind_reg == KIND_FREE)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (magic_ok && sz_reg[0])
                    begin
                        wr_en       = 1'b1;
                        wr_idx      = idx_sz;
                        wr_data     = {sz_reg[63:1], 1'b0};
                        status_next = ST_OK;
                    end
                    else
                    begin
                        status_next = ST_BADFREE;
                    end
                end
                else
                begin
                    priority if (!magic_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OOM;
                        state_next  = S_IDLE;
                    end
                    else if (fits)
                    begin
                        wr_en       = 1'b1;
                        wr_idx      = idx_sz;
                        wr_data     = sz_reg | 64'd1;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        addr_next   = addr_sum[15:0];
                        state_next  = S_IDLE;
                    end
                    else if (sz_big || (b_step + HDR_BYTES > STORE_BYTES))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OOM;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        b_next     = b_step[OFF_W-1:0];
                        prev_next  = prev_low[OFF_W-1:0];
                        state_next = S_RSZ;
                    end
                end
            end
            S_APP:
            begin
                if (need > lim_eff)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OOM;
                    state_next  = S_IDLE;
                end
                else
                begin
                    t_next     = t_sum[OFF_W-1:0];
                    cnt_next   = '0;
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 3'd1;
                unique case (cnt_reg)
                    3'd0:
                    begin
                        wr_idx  = idx_base;
                        wr_data = HEAP_MAGIC;
                    end
                    3'd1:
                    begin
                        wr_idx  = idx_base + idx_t'(1);
                        wr_data = 64'(prev_reg);
                    end
                    3'd2:
                    begin
                        wr_idx  = idx_base + idx_t'(2);
                        wr_data = 64'(n_reg) | 64'd1;
                    end
                    3'd3:
                    begin
                        wr_idx  = idx_base;
                        wr_data = HEAP_MAGIC;
                    end
                    3'd4:
                    begin
                        wr_idx  = idx_base + idx_t'(1);
                        wr_data = 64'(n_reg);
                    end
                    default:
                    begin
                        wr_idx      = idx_base + idx_t'(2);
                        wr_data     = '0;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        addr_next   = addr_sum[15:0];
                        state_next  = S_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            kind_reg   <= KIND_ALLOC;
            lim_reg    <= LIMIT_W'(65536);
            done_reg   <= 1'b0;
            addr_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cnt_reg    <= cnt_next;
            kind_reg   <= kind_next;
            done_reg   <= done_next;
            addr_reg   <= addr_next;
            status_reg <= status_next;
            if (cfg_we)
            begin
                lim_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg    <= b_next;
        prev_reg <= prev_next;
        t_reg    <= t_next;
        n_reg    <= n_next;
        sz_reg   <= sz_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign address = addr_reg;
    assign status  = status_reg;

endmodule
